// ----- hdl/kre_pkg.sv -----
// ----------------------------------------------------------------------------
// Key scan reply emulator package
// Shared item types, event codes and protocol constants.
// ----------------------------------------------------------------------------
package kre_pkg;

   localparam int KEY_BITS       = 24;
   localparam int KEY_BYTE_COUNT = 3;
   localparam int REPLY_REPEATS  = 6;

   localparam logic [6:0] KEY_COMMAND = 7'h42;

   localparam logic [1:0] MODE_REARM      = 2'd0;
   localparam logic [1:0] MODE_STROBE     = 2'd1;
   localparam logic [1:0] MODE_CLOCK_FALL = 2'd2;
   localparam logic [1:0] MODE_CLOCK_RISE = 2'd3;

   localparam int EV_CLOCK_BIT  = 0;
   localparam int EV_STROBE_BIT = 1;

   localparam logic [1:0] EV_NONE  = 2'b00;
   localparam logic [1:0] EV_CLOCK = 2'b01;
   localparam logic [1:0] EV_ALL   = 2'b11;

   typedef struct packed {
      logic [1:0] mode;
      logic       data_in;
   } req_item_type;

   typedef struct packed {
      logic data_out;
      logic data_out_enable;
      logic strobe_release;
      logic replying;
   } rsp_item_type;

endpackage

// ----- hdl/kre_in_stage.sv -----
// ----------------------------------------------------------------------------
// Key scan reply emulator input register
// Holds one pin event item until the engine takes it.
// ----------------------------------------------------------------------------
module kre_in_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  kre_pkg::req_item_type req_item,
   input  logic                  take,
   output logic                  held_valid,
   output kre_pkg::req_item_type held_item
);

   logic                  valid_ff;
   logic                  valid_in;
   kre_pkg::req_item_type item_ff;

   assign req_ready = !valid_ff || take;
   assign valid_in  = (req_valid && req_ready) || (valid_ff && !take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (req_valid && req_ready) begin
         item_ff <= req_item;
      end
   end

   assign held_valid = valid_ff;
   assign held_item  = item_ff;

endmodule

// ----- hdl/kre_engine.sv -----
// ----------------------------------------------------------------------------
// Key scan reply emulator engine
// Bus slave state: command shift, key reply shift-out and repeat count.
// ----------------------------------------------------------------------------
module kre_engine #(
   parameter int KEY_BYTE_COUNT = kre_pkg::KEY_BYTE_COUNT,
   parameter int REPLY_REPEATS  = kre_pkg::REPLY_REPEATS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              step,
   input  kre_pkg::req_item_type             step_item,
   input  logic [kre_pkg::KEY_BITS-1:0]      key_bytes,
   output kre_pkg::rsp_item_type             result
);

   typedef enum logic [1:0] {
      PH_COMMAND = 2'd0,
      PH_REPLY   = 2'd1,
      PH_IDLE    = 2'd2
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic [1:0] event_ff, event_in;
   logic       on_rising_ff, on_rising_in;
   logic [2:0] cmd_pos_ff, cmd_pos_in;
   logic [6:0] cmd_shift_ff, cmd_shift_in;
   logic [2:0] bit_pos_ff, bit_pos_in;
   logic [1:0] byte_idx_ff, byte_idx_in;
   logic [2:0] repeats_ff, repeats_in;
   logic       level_ff, level_in;
   logic       drive_ff, drive_in;
   logic       release_bit;

   logic       rising;
   logic [6:0] shift_new;
   logic [2:0] cmd_pos_next;
   logic [4:0] reply_bit_index;
   logic [2:0] bit_pos_next;
   logic [2:0] byte_sum;
   logic [2:0] repeats_next;

   assign rising          = (step_item.mode == kre_pkg::MODE_CLOCK_RISE);
   assign shift_new       = cmd_shift_ff | (7'(step_item.data_in) << cmd_pos_ff);
   assign cmd_pos_next    = cmd_pos_ff + 3'd1;
   assign reply_bit_index = {byte_idx_ff, bit_pos_ff};
   assign bit_pos_next    = bit_pos_ff + 3'd1;
   assign byte_sum        = {1'b0, byte_idx_ff} + 3'd1;
   assign repeats_next    = repeats_ff + 3'd1;

   always_comb begin
      phase_in     = phase_ff;
      event_in     = event_ff;
      on_rising_in = on_rising_ff;
      cmd_pos_in   = cmd_pos_ff;
      cmd_shift_in = cmd_shift_ff;
      bit_pos_in   = bit_pos_ff;
      byte_idx_in  = byte_idx_ff;
      repeats_in   = repeats_ff;
      level_in     = level_ff;
      drive_in     = drive_ff;
      release_bit  = 1'b0;
      case (step_item.mode)
         kre_pkg::MODE_REARM: begin
            phase_in = PH_IDLE;
            drive_in = 1'b1;
            event_in = kre_pkg::EV_ALL;
         end
         kre_pkg::MODE_STROBE: begin
            if (event_ff[kre_pkg::EV_STROBE_BIT]) begin
               phase_in = PH_COMMAND;
            end
         end
         kre_pkg::MODE_CLOCK_FALL, kre_pkg::MODE_CLOCK_RISE: begin
            if (event_ff[kre_pkg::EV_CLOCK_BIT] && (rising == on_rising_ff)) begin
               if (phase_ff == PH_COMMAND) begin
                  cmd_shift_in = shift_new;
                  cmd_pos_in   = cmd_pos_next;
                  if (cmd_pos_next == 3'd7) begin
                     cmd_pos_in   = 3'd0;
                     cmd_shift_in = 7'd0;
                     if (shift_new == kre_pkg::KEY_COMMAND) begin
                        release_bit  = 1'b1;
                        phase_in     = PH_REPLY;
                        event_in     = kre_pkg::EV_CLOCK;
                        on_rising_in = 1'b1;
                     end else begin
                        phase_in = PH_IDLE;
                        drive_in = 1'b1;
                        event_in = kre_pkg::EV_ALL;
                     end
                  end
               end else if (phase_ff == PH_REPLY) begin
                  if (reply_bit_index < 5'(kre_pkg::KEY_BITS)) begin
                     level_in = key_bytes[reply_bit_index];
                  end
                  bit_pos_in = bit_pos_next;
                  if (bit_pos_next == 3'd0) begin
                     if (byte_sum < 3'(KEY_BYTE_COUNT)) begin
                        byte_idx_in = byte_sum[1:0];
                     end else begin
                        byte_idx_in = 2'd0;
                        if (repeats_next == 3'(REPLY_REPEATS)) begin
                           repeats_in = 3'd0;
                           event_in   = kre_pkg::EV_NONE;
                           drive_in   = 1'b0;
                        end else begin
                           repeats_in = repeats_next;
                           phase_in   = PH_IDLE;
                           drive_in   = 1'b1;
                           event_in   = kre_pkg::EV_ALL;
                        end
                     end
                  end
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_COMMAND;
         event_ff     <= kre_pkg::EV_NONE;
         on_rising_ff <= 1'b0;
         cmd_pos_ff   <= 3'd0;
         cmd_shift_ff <= 7'd0;
         bit_pos_ff   <= 3'd0;
         byte_idx_ff  <= 2'd0;
         repeats_ff   <= 3'd0;
         level_ff     <= 1'b0;
         drive_ff     <= 1'b0;
      end else if (step) begin
         phase_ff     <= phase_in;
         event_ff     <= event_in;
         on_rising_ff <= on_rising_in;
         cmd_pos_ff   <= cmd_pos_in;
         cmd_shift_ff <= cmd_shift_in;
         bit_pos_ff   <= bit_pos_in;
         byte_idx_ff  <= byte_idx_in;
         repeats_ff   <= repeats_in;
         level_ff     <= level_in;
         drive_ff     <= drive_in;
      end
   end

   assign result.data_out        = level_in;
   assign result.data_out_enable = drive_in;
   assign result.strobe_release  = release_bit;
   assign result.replying        = (phase_in == PH_REPLY);

endmodule

// ----- hdl/kre_out_stage.sv -----
// ----------------------------------------------------------------------------
// Key scan reply emulator result register
// Holds one result item until the receiver takes it.
// ----------------------------------------------------------------------------
module kre_out_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  kre_pkg::rsp_item_type load_item,
   output logic                  room,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output kre_pkg::rsp_item_type rsp_item
);

   logic                  valid_ff;
   logic                  valid_in;
   kre_pkg::rsp_item_type item_ff;

   assign room     = !valid_ff || rsp_ready;
   assign valid_in = load || (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load) begin
         item_ff <= load_item;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_item  = item_ff;

endmodule

// ----- hdl/keyscan_reply_emulator_unit.sv -----
// ----------------------------------------------------------------------------
// Key scan reply emulator
// Answers the key-read command of a three-wire display-driver bus with a
// stored key map, one pin event item in and one result item out.
//
// The req channel carries one pin event per item: rearm, strobe falling
// edge, or a clock edge with the sampled data line. The rsp channel returns
// one item per event with the reply line level, its drive enable, the
// strobe release pulse and the reply phase flag after the event.
// The csr port writes the 24-bit key map; write it only while the block has
// no item in flight.
// An item passes an input register and then a result register before its
// result is offered. One item is accepted every cycle for as long as the
// receiver keeps taking results.
// Reset clears the bus state, disables strobe and clock events and clears the key map.
// When the receiver stalls, the result register holds its item and the
// input register holds one more; then req_ready drops until space frees up.
// ----------------------------------------------------------------------------
module keyscan_reply_emulator_unit #(
   parameter int KEY_BYTE_COUNT = kre_pkg::KEY_BYTE_COUNT,
   parameter int REPLY_REPEATS  = kre_pkg::REPLY_REPEATS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  kre_pkg::req_item_type               req_item,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output kre_pkg::rsp_item_type               rsp_item,
   input  logic                                csr_write_enable,
   input  logic [kre_pkg::KEY_BITS-1:0]        csr_write_data
);

   logic [kre_pkg::KEY_BITS-1:0] key_bytes_ff;
   logic                         held_valid;
   kre_pkg::req_item_type        held_item;
   logic                         room;
   logic                         advance;
   kre_pkg::rsp_item_type        step_result;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_bytes_ff <= '0;
      end else if (csr_write_enable) begin
         key_bytes_ff <= csr_write_data;
      end
   end

   assign advance = held_valid && room;

   kre_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_item   (req_item),
      .take       (advance),
      .held_valid (held_valid),
      .held_item  (held_item)
   );

   kre_engine #(
      .KEY_BYTE_COUNT (KEY_BYTE_COUNT),
      .REPLY_REPEATS  (REPLY_REPEATS)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .step_item (held_item),
      .key_bytes (key_bytes_ff),
      .result    (step_result)
   );

   kre_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .load      (advance),
      .load_item (step_result),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

   a_release_in_reply : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.strobe_release) |-> rsp_item.replying)
      else $error("Strobe release item is not in the reply phase.");

   a_release_driven : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.strobe_release) |-> rsp_item.data_out_enable)
      else $error("Strobe release item has the reply line released.");

   a_held_item_kept : assert property (@(posedge clock) disable iff (reset)
      (held_valid && !room) |=> (held_valid && $stable(held_item)))
      else $error("Waiting input item was lost or changed.");

endmodule
